// ----- design/sorted_gradient_stop_table_defines.svh -----
// Assertion macros for the sorted gradient stop table.
// Included by design/sorted_gradient_stop_table.sv; no other dependencies.
`ifndef SORTED_GRADIENT_STOP_TABLE_DEFINES_SVH
`define SORTED_GRADIENT_STOP_TABLE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SGST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_gradient_stop_table: same-cycle check failed");
// next-cycle implication
`define SGST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_gradient_stop_table: next-cycle check failed");
`else
`define SGST_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SGST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/sgst_pkg.sv -----
// Shared types, codes and helpers for the sorted gradient stop table.
// No dependencies; imported by design/sorted_gradient_stop_table.sv.
package sgst_pkg;

    localparam int DEFAULT_MAX_STOPS = 16;

    localparam logic [15:0] Q_ONE = 16'h8000;   // 1.0 in Q1.15

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_IDX  = 2'd2,
        ST_RESERVED = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] ramp;
        logic [15:0] mid;
        logic [31:0] color;
        logic [15:0] opacity;
        logic [6:0]  shade;
    } t_stop;

    // Signed Q2.15 to Q1.15, clamped to 0..1.
    function automatic logic [15:0] clamp_unit(input logic [17:0] v);
        logic [15:0] r;
        if (v[17]) begin
            r = 16'd0;
        end else if (v[16:0] > {1'b0, Q_ONE}) begin
            r = Q_ONE;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- design/sorted_gradient_stop_table.sv -----
// Sorted gradient stop table: top level, table memory and sequencer.
// Depends on design/sgst_pkg.sv and design/sorted_gradient_stop_table_defines.svh.
//
//  channel  dir  signals                          word contents
//  -------  ---  -------------------------------  -------------------------------------
//  s        in   i_s_tvalid/o_s_tready            tuser: operation
//                i_s_tdata[95:0], i_s_tuser[1:0]  tdata: index, ramp, mid, color, opa, shade
//  m        out  o_m_tvalid/i_m_tready            tuser: status
//                o_m_tdata[95:0], o_m_tuser[1:0]  tdata: count, slot, ramp, mid, color, opa, shade
//
// One word at a time. Clear, full, bad index, removing the last entry and inserting
// into an empty table go straight to S_DONE; a read passes through S_RD; a remove shifts
// the entries above it down in S_RM; an insert shifts each larger-ramp stop up in S_INS.
// The walk moves one entry per cycle through the single read / single write port of
// the stop memory, one ramp compare per cycle.
// Reset (i_rst_n low, synchronous) empties the table; the memory itself is not cleared.
// A result waiting on o_m_tvalid does not block the next accept; a finished operation
// waits in its last state until the output register is free.
`include "sorted_gradient_stop_table_defines.svh"

module sorted_gradient_stop_table #(
    parameter int MAX_STOPS = sgst_pkg::DEFAULT_MAX_STOPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [3:0] entry_index, [21:4] ramp_in, [39:22] mid_in, [71:40] stop_color,
    // [87:72] opacity_in, [94:88] shade_in, [95] zero
    input  logic [95:0] i_s_tdata,
    // [1:0] operation
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [4:0] stop_count, [8:5] slot, [24:9] ramp_out, [40:25] mid_out,
    // [72:41] color_out, [88:73] opacity_out, [95:89] shade_out
    output logic [95:0] o_m_tdata,
    // [1:0] status
    output logic [1:0]  o_m_tuser
);
    import sgst_pkg::*;

    localparam int CW = $clog2(MAX_STOPS + 1);          // count width
    localparam int IW = (MAX_STOPS > 2) ? $clog2(MAX_STOPS) : 1;   // address width
    localparam int WW = (CW + 1 > 5) ? CW + 1 : 5;      // compare width

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INS  = 6'b000010,     // walk down, shift larger ramps up
        S_INS0 = 6'b000100,     // every stop was larger: place at slot 0
        S_RM   = 6'b001000,     // walk up, shift entries down
        S_RD   = 6'b010000,     // read data returning
        S_DONE = 6'b100000      // hand result to output register
    } t_state;

    // input fields
    logic [3:0]  in_idx;
    logic [17:0] in_ramp;
    logic [17:0] in_mid;
    t_op         in_op;
    t_stop       in_stop;

    assign in_idx  = i_s_tdata[3:0];
    assign in_ramp = i_s_tdata[21:4];
    assign in_mid  = i_s_tdata[39:22];
    assign in_op   = t_op'(i_s_tuser);

    always_comb begin
        in_stop.ramp    = clamp_unit(in_ramp);
        in_stop.mid     = clamp_unit(in_mid);
        in_stop.color   = i_s_tdata[71:40];
        in_stop.opacity = i_s_tdata[87:72];
        in_stop.shade   = i_s_tdata[94:88];
    end

    // state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_ptr, n_ptr;
    logic [3:0]      r_slot, n_slot;
    t_status         r_status, n_status;
    t_stop           r_res, n_res;
    t_stop           r_new;
    t_stop           r_rdata;
    logic            r_ovalid, n_ovalid;
    logic [1:0]      r_o_status;
    logic [CW-1:0]   r_o_count;
    logic [3:0]      r_o_slot;
    t_stop           r_o_res;

    t_stop           mem [MAX_STOPS];

    // memory port controls
    logic            w_en;
    logic [IW-1:0]   w_addr;
    t_stop           w_data;
    logic [IW-1:0]   rd_addr;

    logic            accept;
    logic            load_out;
    logic            ramp_gt;
    logic [WW-1:0]   cnt_w;
    logic [WW-1:0]   idx_w;
    logic [WW-1:0]   ptr_w;

    assign accept   = i_s_tvalid && o_s_tready;
    assign load_out = (r_state == S_DONE) && (!r_ovalid || i_m_tready);
    assign cnt_w    = WW'(r_count);
    assign idx_w    = WW'(in_idx);
    assign ptr_w    = WW'(r_ptr);
    // the one compare of the walk
    assign ramp_gt  = r_rdata.ramp > r_new.ramp;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_slot   = r_slot;
        n_status = r_status;
        n_res    = r_res;
        w_en     = 1'b0;
        w_addr   = r_ptr;
        w_data   = r_new;
        rd_addr  = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_res    = '0;
                    n_slot   = '0;
                    n_state  = S_DONE;
                    case (in_op)
                        OP_INSERT: begin
                            if (cnt_w >= WW'(MAX_STOPS)) begin
                                n_status = ST_FULL;
                            end else if (r_count == '0) begin
                                w_en    = 1'b1;
                                w_addr  = '0;
                                w_data  = in_stop;
                                n_count = CW'(1);
                            end else begin
                                n_ptr   = IW'(cnt_w - WW'(1));
                                rd_addr = IW'(cnt_w - WW'(1));
                                n_state = S_INS;
                            end
                        end
                        OP_REMOVE: begin
                            n_slot = in_idx;
                            if (idx_w >= cnt_w) begin
                                n_status = ST_BAD_IDX;
                            end else if (idx_w + WW'(1) == cnt_w) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_ptr   = IW'(idx_w);
                                rd_addr = IW'(idx_w + WW'(1));
                                n_state = S_RM;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_READ: begin
                            n_slot = in_idx;
                            if (idx_w >= cnt_w) begin
                                n_status = ST_BAD_IDX;
                            end else begin
                                rd_addr = IW'(idx_w);
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_INS: begin
                // r_rdata holds entry r_ptr
                w_en   = 1'b1;
                w_addr = r_ptr + IW'(1);
                if (ramp_gt) begin
                    w_data = r_rdata;
                    if (r_ptr == '0) begin
                        n_state = S_INS0;
                    end else begin
                        n_ptr   = r_ptr - IW'(1);
                        rd_addr = r_ptr - IW'(1);
                    end
                end else begin
                    w_data  = r_new;
                    n_slot  = 4'(ptr_w + WW'(1));
                    n_count = r_count + CW'(1);
                    n_state = S_DONE;
                end
            end
            S_INS0: begin
                w_en    = 1'b1;
                w_addr  = '0;
                w_data  = r_new;
                n_slot  = '0;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_RM: begin
                // r_rdata holds entry r_ptr + 1
                w_en   = 1'b1;
                w_addr = r_ptr;
                w_data = r_rdata;
                if (ptr_w + WW'(2) < cnt_w) begin
                    n_ptr   = r_ptr + IW'(1);
                    rd_addr = IW'(ptr_w + WW'(2));
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                n_res   = r_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (load_out) begin
            n_ovalid = 1'b1;
        end else if (i_m_tready) begin
            n_ovalid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_slot   <= n_slot;
        r_status <= n_status;
        r_res    <= n_res;
        if (accept) begin
            r_new <= in_stop;
        end
        if (load_out) begin
            r_o_status <= r_status;
            r_o_count  <= r_count;
            r_o_slot   <= r_slot;
            r_o_res    <= r_res;
        end
    end

    // stop memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rdata <= mem[rd_addr];
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_o_status;
    assign o_m_tdata  = {r_o_res.shade, r_o_res.opacity, r_o_res.color, r_o_res.mid,
                         r_o_res.ramp, r_o_slot, 5'(r_o_count)};

    // checks
    `SGST_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, cnt_w <= WW'(MAX_STOPS))
    `SGST_ASSERT_NOW(a_ins_ptr, i_clk, i_rst_n, r_state == S_INS, ptr_w < cnt_w)
    `SGST_ASSERT_NEXT(a_full_drop, i_clk, i_rst_n,
        accept && in_op == OP_INSERT && cnt_w == WW'(MAX_STOPS),
        r_status == ST_FULL && cnt_w == WW'(MAX_STOPS))
    `SGST_ASSERT_NEXT(a_result_out, i_clk, i_rst_n, load_out,
        r_ovalid && r_state == S_IDLE)

endmodule
